FILE: hdl/skl_pkg.sv
package skl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int RANK_WIDTH = 6;
    localparam int COUNT_OUT_WIDTH = 6;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] new_value;
        logic                         clear_first;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  kth_value;
        logic [COUNT_OUT_WIDTH-1:0]    held_count;
        logic                          is_full;
    } out_t;

endpackage

FILE: hdl/stream_kth_largest_tracker_unit.sv
// Tracks the k largest signed values of a stream; k comes from cfg_wdata.
// Input channel in_valid/in_ready/in_data: one request per value, with a
// clear_first bit that empties the held set before the value is added.
// Output channel out_valid/out_ready/out_data: one result per request, giving
// the smallest held value, the number held and a full flag, in request order.
// cfg_we writes rank_k (0 acts as 1, above MAX_RANK acts as MAX_RANK); write
// it only while no request is in flight.
// An accepted request waits in the queue and its result is registered in the
// output register as it leaves the queue. Throughput: one request per cycle
// while results are taken; every held cell compares against the new value in
// parallel and the sorted row shifts in the same cycle.
// A two-entry queue sits between the input side and the cell row, and the
// result sits in an output register, so a stalled receiver holds the row
// while the queue still takes up to two more requests.
// Reset clears the held count, the queue and the output valid; rank_k returns
// to 1. Held values are not cleared.
module stream_kth_largest_tracker_unit #(
    parameter int MAX_RANK = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  skl_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output skl_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [skl_pkg::RANK_WIDTH-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_RANK + 1);

    logic [skl_pkg::RANK_WIDTH-1:0] rank_k_reg;
    logic [skl_pkg::RANK_WIDTH-1:0] rank_k_next;
    logic                           head_valid;
    skl_pkg::in_t                   head_data;
    logic [CNT_W-1:0]               head_k;
    logic                           pop;

    assign rank_k_next = cfg_we ? cfg_wdata : rank_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_k_reg <= skl_pkg::RANK_WIDTH'(1);
        end
        else
        begin
            rank_k_reg <= rank_k_next;
        end
    end

    skl_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .rank_k     (rank_k_reg),
        .max_rank   (CNT_W'(MAX_RANK)),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_k     (head_k)
    );

    skl_back #(
        .MAX_RANK (MAX_RANK),
        .CNT_W    (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_k     (head_k),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: hdl/skl_front.sv
module skl_front #(
    parameter int CNT_W = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  skl_pkg::in_t                      in_data,
    input  logic [skl_pkg::RANK_WIDTH-1:0]    rank_k,
    input  logic [CNT_W-1:0]                  max_rank,
    input  logic                              pop,
    output logic                              head_valid,
    output skl_pkg::in_t                      head_data,
    output logic [CNT_W-1:0]                  head_k
);

    localparam int RW = skl_pkg::RANK_WIDTH;
    localparam int WIDE = (CNT_W > RW) ? CNT_W : RW;

    skl_pkg::in_t      data_mem [2];
    logic [CNT_W-1:0]  k_mem [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        level_reg;
    logic [1:0]        level_next;
    logic              push;
    logic [CNT_W-1:0]  k_eff;
    logic [WIDE-1:0]   rank_wide;
    logic [WIDE-1:0]   max_wide;

    // clamp k to 1..MAX_RANK at acceptance
    assign rank_wide = WIDE'(rank_k);
    assign max_wide  = WIDE'(max_rank);

    always_comb
    begin
        if (rank_k == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (rank_wide > max_wide)
        begin
            k_eff = max_rank;
        end
        else
        begin
            k_eff = CNT_W'(rank_wide);
        end
    end

    assign in_ready   = (level_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (level_reg != 2'd0);
    assign head_data  = data_mem[rd_ptr_reg];
    assign head_k     = k_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_mem[wr_ptr_reg] <= in_data;
            k_mem[wr_ptr_reg]    <= k_eff;
        end
    end

`ifndef SYNTHESIS
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg != 2'd3)
        else $error("queue level out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_k != '0))
        else $error("queued k is zero");
`endif

endmodule

FILE: hdl/skl_back.sv
module skl_back #(
    parameter int MAX_RANK = 32,
    parameter int CNT_W    = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  skl_pkg::in_t       head_data,
    input  logic [CNT_W-1:0]   head_k,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output skl_pkg::out_t      out_data
);

    localparam int DW = skl_pkg::DATA_WIDTH;
    localparam int OW = skl_pkg::COUNT_OUT_WIDTH;

    logic signed [DW-1:0]  held_reg  [MAX_RANK];
    logic signed [DW-1:0]  held_next [MAX_RANK];
    logic [MAX_RANK:0]     lt;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  drop;
    logic                  skip;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    skl_pkg::out_t         out_reg;
    logic [CNT_W+OW-1:0]   count_wide;
    logic signed [DW-1:0]  v;

    assign pop     = head_valid && (!out_valid_reg || out_ready);
    assign v       = head_data.new_value;
    assign cnt_eff = head_data.clear_first ? '0 : count_reg;
    assign drop    = (cnt_eff >= head_k);
    assign skip    = drop && (v <= held_reg[0]);

    // per-cell compare: held entry below the new value
    always_comb
    begin
        lt = '0;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            lt[i] = (i < int'(cnt_eff)) && (held_reg[i] < v);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RANK; i++)
        begin
            held_next[i] = held_reg[i];
            if (!skip)
            begin
                if (drop)
                begin
                    if (lt[i+1])
                    begin
                        held_next[i] = held_reg[(i+1) % MAX_RANK];
                    end
                    else if (lt[i])
                    begin
                        held_next[i] = v;
                    end
                end
                else if (!lt[i])
                begin
                    if (i == 0)
                    begin
                        held_next[i] = v;
                    end
                    else if (lt[(i+MAX_RANK-1) % MAX_RANK])
                    begin
                        held_next[i] = v;
                    end
                    else
                    begin
                        held_next[i] = held_reg[(i+MAX_RANK-1) % MAX_RANK];
                    end
                end
            end
        end
    end

    assign count_next     = (skip || drop) ? cnt_eff : cnt_eff + CNT_W'(1);
    assign count_wide     = {{OW{1'b0}}, count_next};
    assign out_valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < MAX_RANK; i++)
            begin
                held_reg[i] <= held_next[i];
            end
            out_reg.kth_value  <= held_next[0];
            out_reg.held_count <= count_wide[OW-1:0];
            out_reg.is_full    <= (count_next >= head_k);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_RANK)
        else $error("held count above capacity");
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_data.clear_first) |=> (count_reg >= $past(count_reg)))
        else $error("held count shrank without clear");
    a_clear_one: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_data.clear_first) |=> (count_reg == CNT_W'(1)))
        else $error("clear did not leave one value");
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("request popped without result");
`endif

endmodule
